### rtl/core/rbrd_pkg.sv
// Shared types, codes and constants of the region bitmap run-length decoder.
package rbrd_pkg;

    // Widths of positions, counts and totals
    localparam int POS_W    = 14;
    localparam int CNT_W    = 14;
    localparam int TILE_W   = 21;
    localparam int PROD_W   = CNT_W + POS_W;
    localparam int COORD_W  = 10;
    localparam int HELD_W   = 7;
    localparam int CODE_W   = 8;
    localparam int WROW_MIN = 11;

    // Previous-row record that names no row
    localparam int NO_ROW = 2047;

    // Saturation point of the set-cell total
    localparam logic [TILE_W-1:0] TILE_CAP = 21'h100000;

    // Code byte ops, bits 7..6
    typedef enum logic [1:0] {
        OP_SKIP_CELLS = 2'd0,
        OP_RUN        = 2'd1,
        OP_SKIP_ROWS  = 2'd2,
        OP_REPEAT     = 2'd3
    } op_t;

    // Result event kinds
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_RUN    = 2'd1,
        EV_REPEAT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_byte;
        logic              last_byte;
    } in_word_t;

    typedef struct packed {
        kind_t              event_kind;
        logic [COORD_W-1:0] start_col;
        logic [COORD_W-1:0] start_row;
        logic [CNT_W-1:0]   run_count;
        logic [TILE_W-1:0]  tile_total;
        logic               stream_done;
        logic               decode_error;
    } result_t;

    // Add to the set-cell total, saturating at the cap
    function automatic logic [TILE_W-1:0] sat_add(input logic [TILE_W-1:0] base,
                                                  input logic [PROD_W-1:0] amount);
        logic [PROD_W:0] sum;
        sum = (PROD_W+1)'(base) + (PROD_W+1)'(amount);
        return (sum > (PROD_W+1)'(TILE_CAP)) ? TILE_CAP : sum[TILE_W-1:0];
    endfunction

endpackage

### rtl/core/rbrd_core.sv
// Decode state and per-word next-state and result logic of the bitmap decoder.
module rbrd_core #(
    parameter int GRID_SIZE = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  rbrd_pkg::in_word_t in_word,
    output rbrd_pkg::result_t  result
);
    import rbrd_pkg::*;

    localparam int ROW_BITS = $clog2(GRID_SIZE);
    localparam int WROW_W   = (ROW_BITS > WROW_MIN) ? ROW_BITS : WROW_MIN;
    localparam logic [POS_W-1:0]  GRID_LAST = POS_W'(GRID_SIZE - 1);
    localparam logic [POS_W-1:0]  GRID_END  = POS_W'(GRID_SIZE);
    localparam logic [WROW_W-1:0] NO_ROW_W  = WROW_W'(NO_ROW);

    logic [POS_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic              await_reg, await_next;
    logic [POS_W-1:0]  pw_reg, pw_next;
    logic [WROW_W-1:0] wrow_reg, wrow_next;
    logic [TILE_W-1:0] tiles_reg, tiles_next;
    logic              err_reg, err_next;

    op_t               op;
    logic [CNT_W-1:0]  n;
    logic              run;
    logic [POS_W-1:0]  row_m1;
    logic [POS_W-1:0]  above_w;
    logic [PROD_W-1:0] prod;
    logic [POS_W-1:0]  new_m1;
    kind_t             kind;
    logic [POS_W-1:0]  scol;
    logic [POS_W-1:0]  srow;
    logic [CNT_W-1:0]  cnt;

    // Width of the row just above, if it is the recorded one
    assign row_m1  = row_reg - POS_W'(1);
    assign above_w = (POS_W'(wrow_reg) == row_m1) ? pw_reg : '0;
    assign prod    = PROD_W'(n) * PROD_W'(above_w);

    // Decode one word against the current state
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        held_next  = held_reg;
        await_next = await_reg;
        pw_next    = pw_reg;
        wrow_next  = wrow_reg;
        tiles_next = tiles_reg;
        err_next   = err_reg;
        op         = OP_SKIP_CELLS;
        n          = '0;
        run        = 1'b0;
        kind       = EV_NONE;
        scol       = '0;
        srow       = '0;
        cnt        = '0;
        new_m1     = '0;

        // Parse the code, joining a two-byte count
        if (!err_reg) begin
            if (await_reg) begin
                op         = op_t'(held_reg[6:5]);
                n          = CNT_W'({held_reg[4:0], in_word.code_byte}) + CNT_W'(1);
                await_next = 1'b0;
                run        = 1'b1;
            end else if (col_reg > GRID_LAST || row_reg > GRID_LAST) begin
                err_next = 1'b1;
            end else begin
                op = op_t'(in_word.code_byte[7:6]);
                if (in_word.code_byte[5]) begin
                    held_next  = {in_word.code_byte[7:6], in_word.code_byte[4:0]};
                    await_next = 1'b1;
                end else begin
                    n   = CNT_W'(in_word.code_byte[4:0]) + CNT_W'(1);
                    run = 1'b1;
                end
            end
        end

        // Apply the op
        if (run) begin
            case (op)
                OP_SKIP_CELLS: begin
                    col_next = col_reg + POS_W'(n);
                end
                OP_RUN: begin
                    if (POS_W'(wrow_reg) != row_reg) begin
                        pw_next   = POS_W'(n);
                        wrow_next = WROW_W'(row_reg);
                    end else begin
                        pw_next = pw_reg + POS_W'(n);
                    end
                    tiles_next = sat_add(tiles_reg, PROD_W'(n));
                    kind       = EV_RUN;
                    scol       = col_reg;
                    srow       = row_reg;
                    cnt        = n;
                    col_next   = col_reg + POS_W'(n);
                end
                OP_SKIP_ROWS: begin
                    if (col_reg != '0) begin
                        err_next = 1'b1;
                    end else begin
                        row_next = row_reg + POS_W'(n);
                    end
                end
                default: begin
                    // Repeat the previous row
                    if (col_reg != '0 || row_reg == '0) begin
                        err_next = 1'b1;
                    end else begin
                        tiles_next = sat_add(tiles_reg, prod);
                        kind       = EV_REPEAT;
                        srow       = row_reg;
                        cnt        = n;
                        row_next   = row_reg + POS_W'(n);
                        new_m1     = row_next - POS_W'(1);
                        if (new_m1 < POS_W'(NO_ROW)) begin
                            wrow_next = WROW_W'(new_m1);
                            pw_next   = above_w;
                        end else begin
                            wrow_next = NO_ROW_W;
                            pw_next   = '0;
                        end
                    end
                end
            endcase
            // Wrap the column at the grid edge
            if (col_next == GRID_END) begin
                col_next = '0;
                row_next = row_next + POS_W'(1);
            end
        end

        // Check the stream end
        if (in_word.last_byte && (await_next || row_next != GRID_END)) begin
            err_next = 1'b1;
        end

        result.event_kind   = kind;
        result.start_col    = scol[COORD_W-1:0];
        result.start_row    = srow[COORD_W-1:0];
        result.run_count    = cnt;
        result.tile_total   = tiles_next;
        result.stream_done  = in_word.last_byte;
        result.decode_error = err_next;
    end

    // Hold the decode state; clear it after the closing word
    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && in_word.last_byte)) begin
            col_reg   <= '0;
            row_reg   <= '0;
            held_reg  <= '0;
            await_reg <= 1'b0;
            pw_reg    <= '0;
            wrow_reg  <= NO_ROW_W;
            tiles_reg <= '0;
            err_reg   <= 1'b0;
        end else if (fire) begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            held_reg  <= held_next;
            await_reg <= await_next;
            pw_reg    <= pw_next;
            wrow_reg  <= wrow_next;
            tiles_reg <= tiles_next;
            err_reg   <= err_next;
        end
    end

    // Error stays set for the rest of a stream
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg && fire && !in_word.last_byte |=> err_reg)
        else $error("decode error cleared inside a stream");

    // A pending second byte is consumed by the next word
    a_await_once: assert property (@(posedge aclk) disable iff (!aresetn)
        await_reg && fire |=> !await_reg)
        else $error("two-byte code left pending");

    // The total never exceeds its cap
    a_tile_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        tiles_reg <= TILE_CAP)
        else $error("set-cell total above cap");

endmodule

### rtl/core/region_bitmap_rle_decoder.sv
// Top level of the region bitmap run-length decoder: input and result registers.
//
// Decodes a run-length coded square bitmap, one code byte per word.
// Input channel s_*: s_code_byte with s_last_byte marking the final byte of
// a stream. Result channel m_*: one result word per input word, giving the
// event (run of set cells or row repeat), its start column and row, its
// count, the saturating set-cell total, the stream-done mark and the sticky
// decode error. On the closing word the error also reflects the end check.
// An accepted word is held in the input register; when the result register is
// free or drained, the decode logic and the state update land in the result
// register. Throughput is one word per cycle while m_ready stays high,
// limited by the single state update per word (one 14x14 multiply-add for a
// row repeat).
// Reset (aresetn low, synchronous) empties both registers and returns the
// decode state to the start of a stream; the state also returns there after
// each closing word. When m_ready is low the result register holds, the
// input register fills, and s_ready drops until the result is taken.
module region_bitmap_rle_decoder #(
    parameter int GRID_SIZE = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_code_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic [9:0]  m_start_col,
    output logic [9:0]  m_start_row,
    output logic [13:0] m_run_count,
    output logic [20:0] m_tile_total,
    output logic        m_stream_done,
    output logic        m_decode_error
);
    import rbrd_pkg::*;

    logic     in_valid_reg;
    in_word_t in_word_reg;
    logic     out_valid_reg;
    result_t  result_reg;
    result_t  result_next;
    logic     advance;

    // Move a word into the result register when it is free or drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    rbrd_core #(
        .GRID_SIZE(GRID_SIZE)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .in_word (in_word_reg),
        .result  (result_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= '{code_byte: s_code_byte, last_byte: s_last_byte};
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_event_kind   = result_reg.event_kind;
    assign m_start_col    = result_reg.start_col;
    assign m_start_row    = result_reg.start_row;
    assign m_run_count    = result_reg.run_count;
    assign m_tile_total   = result_reg.tile_total;
    assign m_stream_done  = result_reg.stream_done;
    assign m_decode_error = result_reg.decode_error;

    // A held word reaches an empty result register in the next cycle
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("word not advanced into empty result register");

    // Input side is open whenever the input register is empty
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stalled with empty input register");

    // Events carry a nonzero count, idle results a zero one
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_event_kind == EV_NONE) == (m_run_count == '0)))
        else $error("event count mismatch");

    // No event code beyond a row repeat
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_event_kind == EV_NONE || m_event_kind == EV_RUN ||
                     m_event_kind == EV_REPEAT))
        else $error("undefined event kind");

endmodule
